>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the case range table block.
// CRT_ASSERT needs clk_i and rst_ni in the scope where it is used, CRT_ASSERT_ALWAYS only clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define CRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/crt_pkg.sv
// Shared types, constants and the entry transform of the case range table block.
// No dependencies.
package crt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 512;
  localparam int unsigned CP_W   = 21;   // code point width
  localparam int unsigned IDX_W  = 9;    // entry_index width
  localparam int unsigned CNT_W  = 10;   // table_entries width
  localparam int unsigned MODE_W = 3;
  localparam int unsigned OFS_W  = 22;
  localparam int unsigned RES_W  = 24;   // holds cp plus/minus a delta without loss
  localparam int unsigned CMP_W  = 13;   // cell index compare width, covers 4096 cells

  localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_CONVERT = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PLAIN         = 3'd0,
    MODE_EVEN_ODD      = 3'd1,
    MODE_ODD_EVEN      = 3'd2,
    MODE_EVEN_ODD_SKIP = 3'd3,
    MODE_ODD_EVEN_SKIP = 3'd4
  } crt_mode_e;

  // Item as it travels down the cell chain.
  typedef struct packed {
    logic                     kind;
    logic [IDX_W-1:0]         entry_index;
    logic [CP_W-1:0]          range_low;
    logic [CP_W-1:0]          range_high;
    logic [MODE_W-1:0]        record_mode;
    logic signed [OFS_W-1:0]  offset;
    logic [CP_W-1:0]          char_code;
    logic                     done;    // scan finished, later cells pass it on
    logic                     found;
    logic signed [RES_W-1:0]  res;
  } crt_token_t;

  // Apply one matching entry to a code point.
  function automatic logic signed [RES_W-1:0] crt_apply(
    input logic [MODE_W-1:0]       mode,
    input logic                    low_odd,
    input logic [CP_W-1:0]         cp,
    input logic signed [OFS_W-1:0] delta
  );
    logic signed [RES_W-1:0] c;
    logic signed [RES_W-1:0] up;
    logic signed [RES_W-1:0] dn;
    logic signed [RES_W-1:0] r;
    logic                    odd;
    c   = signed'({{(RES_W-CP_W){1'b0}}, cp});
    up  = c + RES_W'(1);
    dn  = c - RES_W'(1);
    odd = cp[0];
    unique case (mode)
      MODE_EVEN_ODD:      r = odd ? dn : up;
      MODE_ODD_EVEN:      r = odd ? up : dn;
      MODE_EVEN_ODD_SKIP: r = (odd != low_odd) ? c : (odd ? dn : up);
      MODE_ODD_EVEN_SKIP: r = (odd != low_odd) ? c : (odd ? up : dn);
      default:            r = c + {{(RES_W-OFS_W){delta[OFS_W-1]}}, delta};
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/case_range_table_converter_unit.sv
// Case range table converter: maps a code point to its case counterpart through a
// sorted table of TableDepth range entries. The table lives in a chain of TableDepth
// cells, one entry per cell; every item (write or convert) walks the chain one cell
// per cycle and then the output register, and a new item is taken every cycle while
// the output is not stalled. An output stall freezes the whole chain. The table
// needs no clearing after reset; entries are written by write items. The user must
// see that they are read only once written; the block itself does not enforce this.
module case_range_table_converter_unit #(
  parameter int unsigned TableDepth = crt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // table_entries register
  input  logic                               cfg_we_i,
  input  logic [crt_pkg::CNT_W-1:0]          cfg_wdata_i,
  // input items
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic [crt_pkg::IDX_W-1:0]          entry_index_i,
  input  logic [crt_pkg::CP_W-1:0]           range_low_i,
  input  logic [crt_pkg::CP_W-1:0]           range_high_i,
  input  logic [crt_pkg::MODE_W-1:0]         record_mode_i,
  input  logic signed [crt_pkg::OFS_W-1:0]   offset_i,
  input  logic [crt_pkg::CP_W-1:0]           char_code_i,
  // result items
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [crt_pkg::CP_W-1:0]           converted_o,
  output logic                               range_found_o,
  output logic                               out_of_range_o
);
  import crt_pkg::*;

  logic [CNT_W-1:0] table_entries_q;
  logic             adv;

  // chain links: index 0 is the input, index k+1 the output of cell k
  logic       vld  [TableDepth+1];
  crt_token_t tok  [TableDepth+1];
  crt_token_t in_tok;

  // output register
  logic            out_valid_q;
  logic [CP_W-1:0] converted_q;
  logic            found_q;
  logic            oor_q;

  crt_token_t last_tok;
  logic       last_conv;
  logic       res_oor;

  // chain moves whenever the output register is free or being taken
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_entries_q <= '0;
    end else if (cfg_we_i) begin
      table_entries_q <= cfg_wdata_i;
    end
  end

  // item enters the chain with an unmatched result equal to its code point
  always_comb begin
    in_tok.kind        = kind_i;
    in_tok.entry_index = entry_index_i;
    in_tok.range_low   = range_low_i;
    in_tok.range_high  = range_high_i;
    in_tok.record_mode = record_mode_i;
    in_tok.offset      = offset_i;
    in_tok.char_code   = char_code_i;
    in_tok.done        = 1'b0;
    in_tok.found       = 1'b0;
    in_tok.res         = signed'({{(RES_W-CP_W){1'b0}}, char_code_i});
  end

  assign vld[0] = in_valid_i;
  assign tok[0] = in_tok;

  for (genvar k = 0; k < TableDepth; k++) begin : g_cell
    crt_cell #(
      .CellIdx (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .cfg_count_i (table_entries_q),
      .vld_i       (vld[k]),
      .tok_i       (tok[k]),
      .vld_o       (vld[k+1]),
      .tok_o       (tok[k+1])
    );
  end

  // final flags; write items report all zero
  assign last_tok  = tok[TableDepth];
  assign last_conv = (last_tok.kind == KIND_CONVERT);
  assign res_oor   = last_tok.res[RES_W-1] ||
                     (last_tok.res[RES_W-2:0] > (RES_W-1)'(CP_MAX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld[TableDepth];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      converted_q <= last_conv ? last_tok.res[CP_W-1:0] : '0;
      found_q     <= last_conv && last_tok.found;
      oor_q       <= last_conv && res_oor;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign converted_o    = converted_q;
  assign range_found_o  = found_q;
  assign out_of_range_o = oor_q;

endmodule

>>> rtl/core/crt_cell.sv
// One cell of the range table chain: holds one table entry and one item stage.
// Depends on crt_pkg.
module crt_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic [crt_pkg::CNT_W-1:0]  cfg_count_i,
  input  logic                       vld_i,
  input  crt_pkg::crt_token_t        tok_i,
  output logic                       vld_o,
  output crt_pkg::crt_token_t        tok_o
);
  import crt_pkg::*;

  localparam logic [CMP_W-1:0] CellIdxC = CMP_W'(CellIdx);

  // entry storage, undefined until written
  logic [CP_W-1:0]          lo_q;
  logic [CP_W-1:0]          hi_q;
  logic [MODE_W-1:0]        mode_q;
  logic signed [OFS_W-1:0]  delta_q;

  logic       vld_q;
  crt_token_t tok_q, tok_d;
  logic       wr_hit;
  logic       scanned;

  assign wr_hit  = vld_i && (tok_i.kind == KIND_WRITE) &&
                   (CMP_W'(tok_i.entry_index) == CellIdxC);
  assign scanned = CMP_W'(cfg_count_i) > CellIdxC;

  always_comb begin
    tok_d = tok_i;
    if (vld_i && (tok_i.kind == KIND_CONVERT) && !tok_i.done) begin
      priority if (!scanned) begin
        tok_d.done = 1'b1;
      end else if (tok_i.char_code < lo_q) begin
        tok_d.done = 1'b1;
      end else if (tok_i.char_code <= hi_q) begin
        tok_d.done  = 1'b1;
        tok_d.found = 1'b1;
        tok_d.res   = crt_apply(mode_q, lo_q[0], tok_i.char_code, delta_q);
      end else begin
        tok_d.done = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
    end
    if (adv_i && wr_hit) begin
      lo_q    <= tok_i.range_low;
      hi_q    <= tok_i.range_high;
      mode_q  <= tok_i.record_mode;
      delta_q <= tok_i.offset;
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

>>> rtl/core/crt_checker.sv
// Port-level checks of the case range table converter, bound to its top level.
// Depends on crt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module crt_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_we_i,
  input logic [crt_pkg::CNT_W-1:0]          cfg_wdata_i,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               kind_i,
  input logic [crt_pkg::IDX_W-1:0]          entry_index_i,
  input logic [crt_pkg::CP_W-1:0]           range_low_i,
  input logic [crt_pkg::CP_W-1:0]           range_high_i,
  input logic [crt_pkg::MODE_W-1:0]         record_mode_i,
  input logic signed [crt_pkg::OFS_W-1:0]   offset_i,
  input logic [crt_pkg::CP_W-1:0]           char_code_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [crt_pkg::CP_W-1:0]           converted_o,
  input logic                               range_found_o,
  input logic                               out_of_range_o
);
  import crt_pkg::*;

  // a result waiting on a stall stays put
  `CRT_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(converted_o) && $stable(range_found_o) && $stable(out_of_range_o), "stalled result changed")

  // input back-pressure only comes from a held result
  `CRT_ASSERT(a_stall_cause, in_stall_o == (out_valid_o && out_stall_i), "input stall without output stall")

  // an unmatched item passes its code point through, flagged iff beyond the code space
  `CRT_ASSERT(a_nomatch_flag, out_valid_o && !range_found_o |-> out_of_range_o == (converted_o > CP_MAX), "unmatched result flag mismatch")

  // nothing is shown while reset is held
  `CRT_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result during reset")

endmodule

bind case_range_table_converter_unit crt_checker u_crt_checker (.*);
